// ===== hdl/gafc_pkg.sv =====
// Shared types, register map and pixel encoding for the glyph alpha format converter.
package gafc_pkg;

  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned MaxOut  = 8;
  localparam int unsigned OutIdxW = $clog2(MaxOut);
  localparam int unsigned OutCntW = $clog2(MaxOut + 1);

  // Register word index, taken from paddr[2].
  typedef enum logic {
    REG_SOURCE_MODE = 1'b0,
    REG_DEST_FORMAT = 1'b1
  } reg_idx_e;

  typedef enum logic {
    SRC_GRAY = 1'b0,
    SRC_MONO = 1'b1
  } src_mode_e;

  typedef enum logic [2:0] {
    FMT_ARGB     = 3'd0,
    FMT_AIRGB    = 3'd1,
    FMT_ARGB4444 = 3'd2,
    FMT_ARGB2554 = 3'd3,
    FMT_ARGB1555 = 3'd4,
    FMT_A8       = 3'd5,
    FMT_A4       = 3'd6,
    FMT_A1       = 3'd7
  } dest_fmt_e;

  typedef struct packed {
    logic [7:0] src_byte;
    logic [3:0] valid_pixels;
    logic       row_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_data;
    logic        last;
    logic        row_done;
  } out_item_t;

  // One unpacked pixel word for the direct formats.
  function automatic logic [31:0] px_word(dest_fmt_e fmt, logic [7:0] c);
    logic [31:0] w;
    case (fmt)
      FMT_ARGB:     w = {c, 24'hFFFFFF};
      FMT_AIRGB:    w = {~c, 24'hFFFFFF};
      FMT_ARGB4444: w = {16'd0, c[7:4], 12'hFFF};
      FMT_ARGB2554: w = {16'd0, c[7:6], 14'h3FFF};
      FMT_ARGB1555: w = {16'd0, c[7], 15'h7FFF};
      default:      w = {24'd0, c};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/glyph_alpha_format_converter.sv =====
// Glyph alpha format converter top level: input stage, pixel conversion, result buffer, APB regs.
//
// Takes one glyph coverage byte per transfer (8-bit gray, or up to eight 1-bit mono pixels
// MSB first) and turns it into destination alpha pixels: ARGB, inverted-alpha ARGB,
// ARGB4444, ARGB2554, ARGB1555 with white color bits, A8, or packed A4/A1 bytes that are
// flushed (zero-padded) at each row end. A source byte is held in the input
// register, is converted in a single pass, and its 0..8 result words are loaded together
// into a result buffer that drains one word per cycle while out_stall_i is low. Gray
// sources run at one byte per cycle when the output does not stall. Mono bytes into
// direct formats give one word per valid pixel. Mono bytes into A4 give up to five words
// (four pairs plus a row-end flush). Mono bytes into A1 give up to two words (a completed
// byte plus a row-end flush). The draining result buffer is what holds the input side
// stalled. Items that produce no result (half an A4 pair, an unfinished A1 byte) pass
// without waiting for the buffer and without touching the output. The last word of an
// item carries last, plus row_done if the item had row_end. source_mode (0x0) and
// dest_format (0x4) are only to be written while the block is idle; the A4/A1 pack state
// survives such a write.
module glyph_alpha_format_converter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  gafc_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output gafc_pkg::out_item_t                 out_item_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gafc_pkg::AddrW-1:0]          paddr,
  input  logic [gafc_pkg::DataW-1:0]          pwdata,
  output logic [gafc_pkg::DataW-1:0]          prdata,
  output logic                                pready
);
  import gafc_pkg::*;

  // config registers
  src_mode_e   src_mode_q;
  dest_fmt_e   dest_fmt_q;
  logic        cfg_wr;

  // input stage
  logic        in_valid_q;
  in_item_t    in_q;
  logic        in_xfer;
  logic        adv;

  // pack state
  logic [7:0]  pack_byte_q, pack_byte_d;
  logic [2:0]  pack_cnt_q, pack_cnt_d;

  // conversion results
  logic [31:0]        words [MaxOut];
  logic [OutCntW-1:0] n_res;
  logic [3:0]         n_pix;

  // result buffer
  logic [31:0]        buf_q [MaxOut];
  logic               out_valid_q;
  logic [OutIdxW-1:0] rd_idx_q;
  logic [OutIdxW-1:0] last_idx_q;
  logic               row_end_q;
  logic               out_last;
  logic               buf_free;

  // ---------------- APB ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_SOURCE_MODE: prdata = {31'd0, src_mode_q};
      REG_DEST_FORMAT: prdata = {29'd0, dest_fmt_q};
      default:         prdata = '0;
    endcase
  end

  // ---------------- handshakes ----------------
  assign out_last = (rd_idx_q == last_idx_q);
  assign buf_free = !out_valid_q || (!out_stall_i && out_last);
  // an item with no results never needs the buffer
  assign adv      = in_valid_q && ((n_res == '0) || buf_free);
  assign in_stall_o = in_valid_q && !adv;
  assign in_xfer  = in_valid_i && !in_stall_o;

  // ---------------- single-pass conversion ----------------
  // Walks up to eight pixels in order; the pack state is an 8-bit byte and a 3-bit count.
  always_comb begin
    logic [7:0] c;
    logic       take;
    pack_byte_d = pack_byte_q;
    pack_cnt_d  = pack_cnt_q;
    n_res       = '0;
    for (int j = 0; j < MaxOut; j++) begin
      words[j] = '0;
    end
    n_pix = (in_q.valid_pixels > 4'd8) ? 4'd8 : in_q.valid_pixels;

    for (int i = 0; i < MaxOut; i++) begin
      if (src_mode_q == SRC_GRAY) begin
        take = (i == 0);
        c    = in_q.src_byte;
      end else begin
        take = (4'(i) < n_pix);
        c    = {8{in_q.src_byte[7-i]}};
      end
      if (take) begin
        case (dest_fmt_q)
          FMT_A4: begin
            if (pack_cnt_d == 3'd0) begin
              pack_byte_d = c & 8'hF0;
              pack_cnt_d  = 3'd1;
            end else begin
              words[n_res[OutIdxW-1:0]] = {24'd0, pack_byte_d | (c >> 4)};
              n_res       = n_res + 1'b1;
              pack_byte_d = '0;
              pack_cnt_d  = '0;
            end
          end
          FMT_A1: begin
            pack_byte_d = pack_byte_d | ((c & 8'h80) >> pack_cnt_d);
            pack_cnt_d  = pack_cnt_d + 3'd1;
            if (pack_cnt_d == 3'd0) begin
              words[n_res[OutIdxW-1:0]] = {24'd0, pack_byte_d};
              n_res       = n_res + 1'b1;
              pack_byte_d = '0;
            end
          end
          default: begin
            words[n_res[OutIdxW-1:0]] = px_word(dest_fmt_q, c);
            n_res = n_res + 1'b1;
          end
        endcase
      end
    end

    // row end: flush a partial packed byte, then clear pack state
    if (in_q.row_end) begin
      if ((dest_fmt_q == FMT_A4 || dest_fmt_q == FMT_A1) && pack_cnt_d != 3'd0) begin
        words[n_res[OutIdxW-1:0]] = {24'd0, pack_byte_d};
        n_res = n_res + 1'b1;
      end
      pack_byte_d = '0;
      pack_cnt_d  = '0;
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_mode_q  <= SRC_GRAY;
      dest_fmt_q  <= FMT_A8;
      in_valid_q  <= 1'b0;
      pack_byte_q <= '0;
      pack_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      rd_idx_q    <= '0;
      last_idx_q  <= '0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx_e'(paddr[2]))
          REG_SOURCE_MODE: src_mode_q <= src_mode_e'(pwdata[0]);
          REG_DEST_FORMAT: dest_fmt_q <= dest_fmt_e'(pwdata[2:0]);
          default: ;
        endcase
      end

      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end

      if (adv) begin
        pack_byte_q <= pack_byte_d;
        pack_cnt_q  <= pack_cnt_d;
      end

      if (adv && n_res != '0) begin
        out_valid_q <= 1'b1;
        rd_idx_q    <= '0;
        last_idx_q  <= OutIdxW'(n_res - 1'b1);
      end else if (out_valid_q && !out_stall_i) begin
        if (out_last) begin
          out_valid_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_item_i;
    end
    if (adv && n_res != '0) begin
      buf_q     <= words;
      row_end_q <= in_q.row_end;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_item_o.out_data = buf_q[rd_idx_q];
  assign out_item_o.last     = out_last;
  assign out_item_o.row_done = out_last & row_end_q;

endmodule

// ===== bench/glyph_alpha_format_converter_tb.sv =====
// Self-checking testbench for the glyph alpha format converter.
`timescale 1ns / 100ps

module glyph_alpha_format_converter_tb;
  import gafc_pkg::*;

  // Cycles the block may still be busy on an item that makes no result
  // (input register plus conversion pass), with some margin.
  localparam int unsigned SettleCycles = 4;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned RandPhases   = 10;
  localparam int unsigned PhaseItems   = 50;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_item_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_item_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [AddrW-1:0]     paddr       = '0;
  logic [DataW-1:0]     pwdata      = '0;
  logic [DataW-1:0]     prdata;
  logic                 pready;

  glyph_alpha_format_converter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the config registers and of the A4/A1 pack state
  // ---------------------------------------------------------------------------
  src_mode_e   mode_q    = SRC_GRAY;   // register reset values
  dest_fmt_e   fmt_q     = FMT_A8;
  logic [7:0]  pack_acc  = '0;         // partial A4/A1 byte
  logic [2:0]  pack_fill = '0;         // pixels already in pack_acc
  logic [31:0] step_words[$];          // words made by the current byte
  out_item_t   pending_pixels[$];      // expected results, oldest first

  int unsigned mismatches = 0;
  bit          snd_idle   = 1'b1;      // sender inserts gaps
  bit          rcv_idle   = 1'b1;      // receiver inserts stalls

  // One coverage value into the current destination format.
  task automatic place_pixel(input logic [7:0] c);
    case (fmt_q)
      FMT_ARGB:     step_words.push_back({c, 24'hFFFFFF});
      FMT_AIRGB:    step_words.push_back({c ^ 8'hFF, 24'hFFFFFF});
      FMT_ARGB4444: step_words.push_back((32'(c & 8'hF0) << 8) | 32'h0000_0FFF);
      FMT_ARGB2554: step_words.push_back((32'(c & 8'hC0) << 8) | 32'h0000_3FFF);
      FMT_ARGB1555: step_words.push_back((32'(c & 8'h80) << 8) | 32'h0000_7FFF);
      FMT_A8:       step_words.push_back(32'(c));
      FMT_A4: begin
        // any nonzero fill counts as a waiting high nibble
        if (pack_fill == 3'd0) begin
          pack_acc  = c & 8'hF0;
          pack_fill = 3'd1;
        end else begin
          step_words.push_back(32'(pack_acc | (c >> 4)));
          pack_acc  = '0;
          pack_fill = '0;
        end
      end
      default: begin
        pack_acc  = pack_acc | ((c & 8'h80) >> pack_fill);
        pack_fill = pack_fill + 3'd1;
        if (pack_fill == 3'd0) begin
          step_words.push_back(32'(pack_acc));
          pack_acc = '0;
        end
      end
    endcase
  endtask

  // All words that one source byte produces, into step_words.
  task automatic convert_byte(input in_item_t it);
    logic [3:0] npix;
    int         i;
    step_words.delete();
    if (mode_q == SRC_GRAY) begin
      place_pixel(it.src_byte);
    end else begin
      npix = (it.valid_pixels > 4'd8) ? 4'd8 : it.valid_pixels;
      for (i = 0; i < npix; i++) place_pixel(it.src_byte[7-i] ? 8'hFF : 8'h00);
    end
    if (it.row_end) begin
      // flush a partial packed byte, zero padded; pack state clears always
      if ((fmt_q == FMT_A4 || fmt_q == FMT_A1) && pack_fill != 3'd0)
        step_words.push_back(32'(pack_acc));
      pack_acc  = '0;
      pack_fill = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side: random gap, then hold the byte until the transfer
  // ---------------------------------------------------------------------------
  task automatic feed_byte(input in_item_t it, input bit typed, input logic [31:0] word);
    int unsigned gap;
    out_item_t   res;
    gap = snd_idle ? $urandom_range(0, 8) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    // transfer taken: advance the predictor
    convert_byte(it);
    if (typed) begin
      // hand-typed single result replaces the predicted words
      step_words.delete();
      step_words.push_back(word);
    end
    foreach (step_words[j]) begin
      res.out_data = step_words[j];
      res.last     = (j == step_words.size() - 1);
      res.row_done = res.last && it.row_end;
      pending_pixels.push_back(res);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Config port: only touched once the block has gone quiet
  // ---------------------------------------------------------------------------
  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    // a byte with no result may still be in flight
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);              // setup phase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);              // access phase
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input src_mode_e m, input dest_fmt_e f);
    drain_block();
    write_reg(REG_SOURCE_MODE, 32'(m));
    write_reg(REG_DEST_FORMAT, 32'(f));
    mode_q = m;
    fmt_q  = f;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall per result, field-wise check on each transfer
  // ---------------------------------------------------------------------------
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_pixels.size() == 0) begin
      $error("unexpected result: out_data 0x%08h", got.out_data);
      mismatches++;
    end else begin
      want = pending_pixels.pop_front();
      if (got.out_data !== want.out_data) begin
        $error("out_data: expected 0x%08h, actual 0x%08h", want.out_data, got.out_data);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        mismatches++;
      end
      if (got.row_done !== want.row_done) begin
        $error("row_done: expected %0b, actual %0b", want.row_done, got.row_done);
        mismatches++;
      end
    end
  endtask

  initial begin : result_sink
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      hold = rcv_idle ? $urandom_range(0, 8) : 0;
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      check_result(out_item_o);
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed bytes. Each row names the config it runs under; a new config is
  // written (after draining) whenever it differs from the current one.
  // typed rows carry their single expected word; the rest go to the predictor.
  // ---------------------------------------------------------------------------
  typedef struct {
    src_mode_e   mode;
    dest_fmt_e   fmt;
    in_item_t    item;
    bit          typed;
    logic [31:0] word;
  } dir_row_t;

  dir_row_t dir_rows [25] = '{
    // reset config: gray into A8
    '{SRC_GRAY, FMT_A8,       '{8'h00, 4'd0,  1'b0}, 1'b1, 32'h0000_0000},
    '{SRC_GRAY, FMT_A8,       '{8'hFF, 4'd0,  1'b1}, 1'b1, 32'h0000_00FF},
    // direct formats at the coverage extremes and at mid values
    '{SRC_GRAY, FMT_ARGB,     '{8'hFF, 4'd0,  1'b0}, 1'b1, 32'hFFFF_FFFF},
    '{SRC_GRAY, FMT_AIRGB,    '{8'h00, 4'hF,  1'b0}, 1'b1, 32'hFFFF_FFFF},
    '{SRC_GRAY, FMT_ARGB4444, '{8'hA5, 4'd0,  1'b0}, 1'b0, 32'h0},
    '{SRC_GRAY, FMT_ARGB2554, '{8'hC3, 4'd0,  1'b1}, 1'b0, 32'h0},
    '{SRC_GRAY, FMT_ARGB1555, '{8'h80, 4'd0,  1'b1}, 1'b1, 32'h0000_FFFF},
    // A4: half pair silent, full pair, partial pair flushed at row end
    '{SRC_GRAY, FMT_A4,       '{8'hAB, 4'd0,  1'b0}, 1'b0, 32'h0},
    '{SRC_GRAY, FMT_A4,       '{8'hCD, 4'd0,  1'b0}, 1'b0, 32'h0},
    '{SRC_GRAY, FMT_A4,       '{8'h7F, 4'd0,  1'b1}, 1'b0, 32'h0},
    // mono into A1: full byte, short row end, zero pixels, saturation
    '{SRC_MONO, FMT_A1,       '{8'hFF, 4'd8,  1'b0}, 1'b1, 32'h0000_00FF},
    '{SRC_MONO, FMT_A1,       '{8'hA0, 4'd3,  1'b1}, 1'b0, 32'h0},
    '{SRC_MONO, FMT_A1,       '{8'h55, 4'd0,  1'b0}, 1'b0, 32'h0},
    '{SRC_MONO, FMT_A1,       '{8'hF0, 4'hF,  1'b1}, 1'b0, 32'h0},
    '{SRC_MONO, FMT_A1,       '{8'h00, 4'd0,  1'b1}, 1'b0, 32'h0},
    // mono expansion into direct formats
    '{SRC_MONO, FMT_ARGB,     '{8'hA5, 4'd8,  1'b1}, 1'b0, 32'h0},
    '{SRC_MONO, FMT_A8,       '{8'h81, 4'd1,  1'b0}, 1'b0, 32'h0},
    // pack state carried across format changes
    '{SRC_MONO, FMT_A4,       '{8'hC0, 4'd3,  1'b0}, 1'b0, 32'h0},
    '{SRC_MONO, FMT_A1,       '{8'h80, 4'd1,  1'b1}, 1'b0, 32'h0},
    '{SRC_MONO, FMT_A1,       '{8'hE0, 4'd3,  1'b0}, 1'b0, 32'h0},
    '{SRC_GRAY, FMT_A4,       '{8'h5A, 4'd0,  1'b0}, 1'b0, 32'h0},
    '{SRC_GRAY, FMT_A4,       '{8'h33, 4'd0,  1'b1}, 1'b0, 32'h0},
    '{SRC_MONO, FMT_AIRGB,    '{8'h0F, 4'd4,  1'b0}, 1'b0, 32'h0},
    '{SRC_MONO, FMT_ARGB2554, '{8'hFF, 4'd9,  1'b1}, 1'b0, 32'h0},
    '{SRC_GRAY, FMT_ARGB1555, '{8'h7F, 4'd0,  1'b0}, 1'b1, 32'h0000_7FFF}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_item_t    it;
    src_mode_e   m;
    dest_fmt_e   f;
    int unsigned ph;
    int unsigned n;
    int          row_left;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].mode != mode_q || dir_rows[r].fmt != fmt_q)
        set_config(dir_rows[r].mode, dir_rows[r].fmt);
      feed_byte(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].word);
    end

    // Random phases: extremes of the config first, then random settings.
    // Rows of 1..12 bytes with a rare stray row end as noise.
    for (ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0:       begin m = SRC_GRAY; f = FMT_ARGB; end
        1:       begin m = SRC_MONO; f = FMT_A1;   end
        2:       begin m = SRC_MONO; f = FMT_ARGB; end
        3:       begin m = SRC_GRAY; f = FMT_A1;   end
        default: begin
          m = src_mode_e'($urandom_range(0, 1));
          f = dest_fmt_e'($urandom_range(0, 7));
        end
      endcase
      set_config(m, f);
      // now and then a phase runs flat out on one or both sides
      snd_idle = ($urandom_range(0, 3) != 0);
      rcv_idle = ($urandom_range(0, 3) != 0);
      row_left = $urandom_range(1, 12);
      for (n = 0; n < PhaseItems; n++) begin
        it.src_byte     = 8'($urandom);
        // mostly legal pixel counts, sometimes zero or above eight
        it.valid_pixels = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                      : 4'($urandom_range(1, 8));
        row_left--;
        it.row_end      = (row_left <= 0) || ($urandom_range(0, 30) == 0);
        if (it.row_end) row_left = $urandom_range(1, 12);
        feed_byte(it, 1'b0, 32'h0);
      end
    end

    // wait for the last results, then wait SettleCycles more to catch strays
    drain_block();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/gafc_pkg.sv
hdl/glyph_alpha_format_converter.sv
bench/glyph_alpha_format_converter_tb.sv
